// File: src/dpw_pkg.sv
// ----------------------------------------------------------------------------
// dpw_pkg: shared types and constants for the depth pixel back-projection
// Register codes, configuration bundles, fixed-point scales and widths.
// ----------------------------------------------------------------------------
package dpw_pkg;

	// configuration register codes
	typedef enum logic [2:0] {
		CFG_ROT_X   = 3'd0,
		CFG_ROT_Y   = 3'd1,
		CFG_ROT_Z   = 3'd2,
		CFG_TRANS_X = 3'd3,
		CFG_TRANS_Y = 3'd4,
		CFG_TRANS_Z = 3'd5,
		CFG_PRINC   = 3'd6,
		CFG_INV_FOC = 3'd7
	} cfg_index_t;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 48;

	localparam logic [47:0] ROT_X_RESET = 48'h0000_0000_4000;
	localparam logic [47:0] ROT_Y_RESET = 48'h0000_4000_0000;
	localparam logic [47:0] ROT_Z_RESET = 48'h4000_0000_0000;

	// depth codes that carry no measurement
	localparam logic [15:0] DEPTH_NONE_LO = 16'h0000;
	localparam logic [15:0] DEPTH_NONE_HI = 16'hFFFF;

	// fixed-point scales
	localparam int CAM_SHIFT = 20;  // Q.28 camera product down to Q.8
	localparam int ACC_SHIFT = 22;  // Q1.14 times Q.8 down to whole mm
	localparam int ZC_SHIFT  = 8;   // depth in Q.8
	localparam int IFX_SPLIT = 12;  // reciprocal cut into two partial products
	localparam int XC_SPLIT  = 20;  // camera coordinate cut for the rotation

	localparam int WORLD_BITS = 24;
	localparam int SAT_MAX    = 8388607;
	localparam int SAT_MIN    = -8388608;

	// pipeline depth per section
	localparam int BP_STAGES   = 5;
	localparam int POSE_STAGES = 5;
	localparam int PIPE_DEPTH  = BP_STAGES + POSE_STAGES;

	// camera intrinsics as held in the register file
	typedef struct packed {
		logic [23:0] ify;
		logic [23:0] ifx;
		logic [15:0] cy;
		logic [15:0] cx;
	} cam_cfg_t;

	// one row of the pose: three Q1.14 coefficients and a translation in mm
	typedef struct packed {
		logic signed [15:0] c2;
		logic signed [15:0] c1;
		logic signed [15:0] c0;
		logic signed [23:0] t;
	} pose_row_t;

	// stage enables and the measurement flag for one axis datapath
	typedef struct packed {
		logic [POSE_STAGES-1:0] en;
		logic                   meas;
	} axis_ctrl_t;

	// signed width of the sub-pixel offset 16*c - cx
	function automatic int dc_width(input int pib);
		return (pib + 5 > 17) ? pib + 5 : 17;
	endfunction

	// signed width of the rounded camera coordinate in Q.8
	function automatic int xc_width(input int pib);
		return dc_width(pib) + 17 + 25 - CAM_SHIFT;
	endfunction

endpackage

// File: src/dpw_backproj.sv
// ----------------------------------------------------------------------------
// dpw_backproj: pinhole back-projection pipeline
// Five stages from a depth pixel to camera-frame x and y in Q.8 millimetres.
// ----------------------------------------------------------------------------
module dpw_backproj #(
	parameter int PIXEL_INDEX_BITS = 11,
	localparam int XW = dpw_pkg::xc_width(PIXEL_INDEX_BITS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [PIXEL_INDEX_BITS-1:0]   pixel_row,
	input  logic [PIXEL_INDEX_BITS-1:0]   pixel_col,
	input  logic [15:0]                   depth_mm,
	input  dpw_pkg::cam_cfg_t             cam,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [XW-1:0]          xc,
	output logic signed [XW-1:0]          yc,
	output logic [15:0]                   depth_out,
	output logic                          meas_out
);

	localparam int NS = dpw_pkg::BP_STAGES;
	localparam int DW = dpw_pkg::dc_width(PIXEL_INDEX_BITS);
	localparam int MW = DW + 17;
	localparam int HW = MW + dpw_pkg::IFX_SPLIT + 1;
	localparam int PW = MW + 25;
	localparam logic signed [PW-1:0] CAM_HALF = PW'(1) <<< (dpw_pkg::CAM_SHIFT - 1);

	logic [NS-1:0] stage_vld_q;
	logic [NS-1:0] en;

	logic signed [DW-1:0] dc_s1, dr_s1;
	logic [15:0]          d_s1, d_s2, d_s3, d_s4, d_s5;
	logic                 meas_s1, meas_s2, meas_s3, meas_s4, meas_s5;
	logic signed [MW-1:0] mx_s2, my_s2;
	logic signed [HW-1:0] xl_s3, xh_s3, yl_s3, yh_s3;
	logic signed [PW-1:0] px_s4, py_s4;
	logic signed [XW-1:0] xc_s5, yc_s5;
	logic signed [PW-1:0] px_rnd, py_rnd;

	// a stage moves when it is empty or the one after it moves
	always_comb begin
		en[NS-1] = ~stage_vld_q[NS-1] | out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = ~stage_vld_q[k] | en[k+1];
		end
	end

	assign in_ready = en[0];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (en[0]) begin
				stage_vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	// stage 1: sub-pixel offsets from the principal point, depth check
	always_ff @(posedge clk) begin
		if (en[0]) begin
			dc_s1   <= DW'($signed({1'b0, pixel_col, 4'b0000})) - DW'($signed({1'b0, cam.cx}));
			dr_s1   <= DW'($signed({1'b0, pixel_row, 4'b0000})) - DW'($signed({1'b0, cam.cy}));
			d_s1    <= depth_mm;
			meas_s1 <= (depth_mm != dpw_pkg::DEPTH_NONE_LO) && (depth_mm != dpw_pkg::DEPTH_NONE_HI);
		end
	end

	// stage 2: offset times depth
	always_ff @(posedge clk) begin
		if (en[1]) begin
			mx_s2   <= MW'(dc_s1) * MW'($signed({1'b0, d_s1}));
			my_s2   <= MW'(dr_s1) * MW'($signed({1'b0, d_s1}));
			d_s2    <= d_s1;
			meas_s2 <= meas_s1;
		end
	end

	// stage 3: partial products with the two halves of each reciprocal
	always_ff @(posedge clk) begin
		if (en[2]) begin
			xl_s3   <= HW'(mx_s2) * HW'($signed({1'b0, cam.ifx[dpw_pkg::IFX_SPLIT-1:0]}));
			xh_s3   <= HW'(mx_s2) * HW'($signed({1'b0, cam.ifx[23:dpw_pkg::IFX_SPLIT]}));
			yl_s3   <= HW'(my_s2) * HW'($signed({1'b0, cam.ify[dpw_pkg::IFX_SPLIT-1:0]}));
			yh_s3   <= HW'(my_s2) * HW'($signed({1'b0, cam.ify[23:dpw_pkg::IFX_SPLIT]}));
			d_s3    <= d_s2;
			meas_s3 <= meas_s2;
		end
	end

	// stage 4: join the partial products into Q.28
	always_ff @(posedge clk) begin
		if (en[3]) begin
			px_s4   <= (PW'(xh_s3) <<< dpw_pkg::IFX_SPLIT) + PW'(xl_s3);
			py_s4   <= (PW'(yh_s3) <<< dpw_pkg::IFX_SPLIT) + PW'(yl_s3);
			d_s4    <= d_s3;
			meas_s4 <= meas_s3;
		end
	end

	// stage 5: round half up to Q.8
	assign px_rnd = px_s4 + CAM_HALF;
	assign py_rnd = py_s4 + CAM_HALF;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			xc_s5   <= px_rnd[PW-1:dpw_pkg::CAM_SHIFT];
			yc_s5   <= py_rnd[PW-1:dpw_pkg::CAM_SHIFT];
			d_s5    <= d_s4;
			meas_s5 <= meas_s4;
		end
	end

	assign out_valid = stage_vld_q[NS-1];
	assign xc        = xc_s5;
	assign yc        = yc_s5;
	assign depth_out = d_s5;
	assign meas_out  = meas_s5;

endmodule

// File: src/dpw_axis.sv
// ----------------------------------------------------------------------------
// dpw_axis: one world axis of the rigid pose
// Rotation row times the camera point, rounding, translation and saturation.
// ----------------------------------------------------------------------------
module dpw_axis #(
	parameter int XW = 39
) (
	input  logic                      clk,
	input  dpw_pkg::axis_ctrl_t       ctrl,
	input  dpw_pkg::pose_row_t        row,
	input  logic signed [XW-1:0]      xc,
	input  logic signed [XW-1:0]      yc,
	input  logic [15:0]               depth,
	output logic signed [23:0]        world
);

	localparam int LW = dpw_pkg::XC_SPLIT;
	localparam int HW = XW - LW;
	localparam int PLW = 16 + LW + 1;
	localparam int PHW = 16 + HW;
	localparam int PZW = 16 + 17;
	localparam int AW = XW + 18;
	localparam int RW = AW - dpw_pkg::ACC_SHIFT;
	localparam int VW = RW + 1;
	localparam logic signed [AW-1:0] ACC_HALF = AW'(1) <<< (dpw_pkg::ACC_SHIFT - 1);
	localparam logic signed [VW-1:0] V_MAX = VW'(dpw_pkg::SAT_MAX);
	localparam logic signed [VW-1:0] V_MIN = VW'(dpw_pkg::SAT_MIN);

	logic signed [PLW-1:0] pxl_s6, pyl_s6;
	logic signed [PHW-1:0] pxh_s6, pyh_s6;
	logic signed [PZW-1:0] pz_s6;
	logic signed [AW-1:0]  tx_s7, ty_s7, tz_s7;
	logic signed [AW-1:0]  sxy_s8, tzh_s8;
	logic signed [AW-1:0]  acc;
	logic signed [RW-1:0]  rnd_s9;
	logic signed [VW-1:0]  v;
	logic signed [23:0]    sat;
	logic signed [23:0]    world_s10;

	// stage 6: coefficient times each half of the camera coordinates
	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			pxl_s6 <= PLW'(row.c0) * PLW'($signed({1'b0, xc[LW-1:0]}));
			pxh_s6 <= PHW'(row.c0) * PHW'($signed(xc[XW-1:LW]));
			pyl_s6 <= PLW'(row.c1) * PLW'($signed({1'b0, yc[LW-1:0]}));
			pyh_s6 <= PHW'(row.c1) * PHW'($signed(yc[XW-1:LW]));
			pz_s6  <= PZW'(row.c2) * PZW'($signed({1'b0, depth}));
		end
	end

	// stage 7: join partial products, depth term into Q.22
	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			tx_s7 <= (AW'(pxh_s6) <<< LW) + AW'(pxl_s6);
			ty_s7 <= (AW'(pyh_s6) <<< LW) + AW'(pyl_s6);
			tz_s7 <= AW'(pz_s6) <<< dpw_pkg::ZC_SHIFT;
		end
	end

	// stage 8: first level of the sum, rounding half folded in
	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			sxy_s8 <= tx_s7 + ty_s7;
			tzh_s8 <= tz_s7 + ACC_HALF;
		end
	end

	// stage 9: final sum and floor to whole millimetres
	assign acc = sxy_s8 + tzh_s8;

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			rnd_s9 <= acc[AW-1:dpw_pkg::ACC_SHIFT];
		end
	end

	// stage 10: translation, saturation, zero point without a measurement
	assign v = VW'(rnd_s9) + VW'(row.t);

	always_comb begin
		if (v > V_MAX) begin
			sat = 24'(V_MAX);
		end else if (v < V_MIN) begin
			sat = 24'(V_MIN);
		end else begin
			sat = v[23:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[4]) begin
			world_s10 <= ctrl.meas ? sat : '0;
		end
	end

	assign world = world_s10;

endmodule

// File: src/dpw_pose.sv
// ----------------------------------------------------------------------------
// dpw_pose: pose section of the pipeline
// Five-stage flow control shared by the three axis datapaths.
// ----------------------------------------------------------------------------
module dpw_pose #(
	parameter int XW = 39
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [XW-1:0]  xc,
	input  logic signed [XW-1:0]  yc,
	input  logic [15:0]           depth,
	input  logic                  meas,
	input  dpw_pkg::pose_row_t    row_x,
	input  dpw_pkg::pose_row_t    row_y,
	input  dpw_pkg::pose_row_t    row_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [23:0]    world_x,
	output logic signed [23:0]    world_y,
	output logic signed [23:0]    world_z,
	output logic                  point_valid
);

	localparam int NS = dpw_pkg::POSE_STAGES;

	logic [NS-1:0]       stage_vld_q;
	logic [NS-1:0]       en;
	logic [NS-1:0]       meas_q;
	dpw_pkg::axis_ctrl_t ctrl;

	// a stage moves when it is empty or the one after it moves
	always_comb begin
		en[NS-1] = ~stage_vld_q[NS-1] | out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = ~stage_vld_q[k] | en[k+1];
		end
	end

	assign in_ready = en[0];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (en[0]) begin
				stage_vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	// measurement flag alongside the axis stages
	always_ff @(posedge clk) begin
		if (en[0]) begin
			meas_q[0] <= meas;
		end
		for (int k = 1; k < NS; k++) begin
			if (en[k]) begin
				meas_q[k] <= meas_q[k-1];
			end
		end
	end

	assign ctrl.en   = en;
	assign ctrl.meas = meas_q[NS-2];

	dpw_axis #(.XW(XW)) u_axis_x (
		.clk   (clk),
		.ctrl  (ctrl),
		.row   (row_x),
		.xc    (xc),
		.yc    (yc),
		.depth (depth),
		.world (world_x)
	);

	dpw_axis #(.XW(XW)) u_axis_y (
		.clk   (clk),
		.ctrl  (ctrl),
		.row   (row_y),
		.xc    (xc),
		.yc    (yc),
		.depth (depth),
		.world (world_y)
	);

	dpw_axis #(.XW(XW)) u_axis_z (
		.clk   (clk),
		.ctrl  (ctrl),
		.row   (row_z),
		.xc    (xc),
		.yc    (yc),
		.depth (depth),
		.world (world_z)
	);

	assign out_valid   = stage_vld_q[NS-1];
	assign point_valid = meas_q[NS-1];

endmodule

// File: src/depth_pixel_to_world_point.sv
// Pipeline: ten register stages; the accepting edge loads the first, and the
//   result is on m_tvalid once it has reached the last.
// Throughput: one item per cycle while m_tready is high; multipliers pipelined.
// Stalls close up empty stages, so s_tready drops only when all ten are full.
// Reset: arst_n clears every valid bit at once and loads the register reset
//   values (identity rotation, zero translation, intrinsics zero).
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point: depth pixel to world point
// Pinhole back-projection and rigid pose in fixed point, with register file.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point #(
	parameter int PIXEL_INDEX_BITS = 11
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                s_tvalid,
	output logic                                                s_tready,
	// pixel_row, pixel_col, depth_mm, zero fill
	input  logic [((2*PIXEL_INDEX_BITS+16+7)/8)*8-1:0]          s_tdata,
	output logic                                                m_tvalid,
	input  logic                                                m_tready,
	// world_x, world_y, world_z
	output logic [3*dpw_pkg::WORLD_BITS-1:0]                    m_tdata,
	// point_valid
	output logic                                                m_tuser,
	input  logic                                                cfg_we,
	input  logic [dpw_pkg::CFG_INDEX_BITS-1:0]                  cfg_index,
	input  logic [dpw_pkg::CFG_DATA_BITS-1:0]                   cfg_wdata
);

	localparam int PB = PIXEL_INDEX_BITS;
	localparam int XW = dpw_pkg::xc_width(PIXEL_INDEX_BITS);

	logic [47:0] rot_x_q, rot_y_q, rot_z_q;
	logic [23:0] trans_x_q, trans_y_q, trans_z_q;
	logic [31:0] princ_q;
	logic [47:0] inv_foc_q;

	dpw_pkg::cam_cfg_t  cam;
	dpw_pkg::pose_row_t row_x, row_y, row_z;

	logic                 bp_valid, bp_ready;
	logic signed [XW-1:0] bp_xc, bp_yc;
	logic [15:0]          bp_depth;
	logic                 bp_meas;
	logic signed [23:0]   world_x, world_y, world_z;

	// register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q   <= dpw_pkg::ROT_X_RESET;
			rot_y_q   <= dpw_pkg::ROT_Y_RESET;
			rot_z_q   <= dpw_pkg::ROT_Z_RESET;
			trans_x_q <= '0;
			trans_y_q <= '0;
			trans_z_q <= '0;
			princ_q   <= '0;
			inv_foc_q <= '0;
		end else if (cfg_we) begin
			unique case (dpw_pkg::cfg_index_t'(cfg_index))
				dpw_pkg::CFG_ROT_X:   rot_x_q   <= cfg_wdata;
				dpw_pkg::CFG_ROT_Y:   rot_y_q   <= cfg_wdata;
				dpw_pkg::CFG_ROT_Z:   rot_z_q   <= cfg_wdata;
				dpw_pkg::CFG_TRANS_X: trans_x_q <= cfg_wdata[23:0];
				dpw_pkg::CFG_TRANS_Y: trans_y_q <= cfg_wdata[23:0];
				dpw_pkg::CFG_TRANS_Z: trans_z_q <= cfg_wdata[23:0];
				dpw_pkg::CFG_PRINC:   princ_q   <= cfg_wdata[31:0];
				dpw_pkg::CFG_INV_FOC: inv_foc_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// configuration bundles for the two sections
	assign cam.cx  = princ_q[15:0];
	assign cam.cy  = princ_q[31:16];
	assign cam.ifx = inv_foc_q[23:0];
	assign cam.ify = inv_foc_q[47:24];

	assign row_x = '{c2: rot_x_q[47:32], c1: rot_x_q[31:16], c0: rot_x_q[15:0], t: trans_x_q};
	assign row_y = '{c2: rot_y_q[47:32], c1: rot_y_q[31:16], c0: rot_y_q[15:0], t: trans_y_q};
	assign row_z = '{c2: rot_z_q[47:32], c1: rot_z_q[31:16], c0: rot_z_q[15:0], t: trans_z_q};

	dpw_backproj #(.PIXEL_INDEX_BITS(PIXEL_INDEX_BITS)) u_backproj (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.pixel_row (s_tdata[PB-1:0]),
		.pixel_col (s_tdata[2*PB-1:PB]),
		.depth_mm  (s_tdata[2*PB+15:2*PB]),
		.cam       (cam),
		.out_valid (bp_valid),
		.out_ready (bp_ready),
		.xc        (bp_xc),
		.yc        (bp_yc),
		.depth_out (bp_depth),
		.meas_out  (bp_meas)
	);

	dpw_pose #(.XW(XW)) u_pose (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (bp_valid),
		.in_ready    (bp_ready),
		.xc          (bp_xc),
		.yc          (bp_yc),
		.depth       (bp_depth),
		.meas        (bp_meas),
		.row_x       (row_x),
		.row_y       (row_y),
		.row_z       (row_z),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.world_x     (world_x),
		.world_y     (world_y),
		.world_z     (world_z),
		.point_valid (m_tuser)
	);

	assign m_tdata = {world_z, world_y, world_x};

endmodule

// File: src/dpw_checker.sv
// ----------------------------------------------------------------------------
// dpw_checker: port-level checks for the world point block
// Tracks items in flight and watches output holding and zero points.
// ----------------------------------------------------------------------------
module dpw_checker (
	input logic                                        clk,
	input logic                                        arst_n,
	input logic                                        s_tvalid,
	input logic                                        s_tready,
	input logic                                        m_tvalid,
	input logic                                        m_tready,
	input logic [3*dpw_pkg::WORLD_BITS-1:0]            m_tdata,
	input logic                                        m_tuser
);

	logic [4:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// items accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 5'd1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 5'd1;
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed under stall");

	// a point without a measurement is the zero point
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("invalid point not zero");

	// with the output stage empty the pipe always takes an item
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// no result without an item in flight, never more than the stages hold
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid |-> inflight_q != 5'd0) and
		(inflight_q <= 5'(dpw_pkg::PIPE_DEPTH)))
		else $error("item count out of range");

endmodule

bind depth_pixel_to_world_point dpw_checker u_chk (.*);

// File: tb/tb_depth_pixel_to_world_point.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_depth_pixel_to_world_point: self-checking bench for the depth back-projector
// Drives depth pixels through the stream port under several camera and pose
// settings and idle mixes. Each accepted pixel is projected by a fixed-point
// predictor, and each output item is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_depth_pixel_to_world_point;
	import dpw_pkg::*;

	localparam int PIB    = 11;
	localparam int DATA_W = ((2*PIB+16+7)/8)*8;

	// one world point as it leaves the block
	typedef struct packed {
		logic        valid;
		logic [23:0] z;
		logic [23:0] y;
		logic [23:0] x;
	} world_point_t;

	// one full register setting
	typedef struct packed {
		logic [47:0] ifoc;
		logic [31:0] princ;
		logic [23:0] tz;
		logic [23:0] ty;
		logic [23:0] tx;
		logic [47:0] rz;
		logic [47:0] ry;
		logic [47:0] rx;
	} cam_setting_t;

	// expected points and the camera and pose they are projected with
	class point_scoreboard;
		logic [47:0]        rot [3];
		logic signed [23:0] trans [3];
		logic [31:0]        princ;
		logic [47:0]        inv_foc;
		world_point_t       expected_points[$];
		int                 errors;
		int                 checked;
		int                 no_measurement;
		int                 saturated;

		function new();
			rot[0] = ROT_X_RESET;
			rot[1] = ROT_Y_RESET;
			rot[2] = ROT_Z_RESET;
			for (int a = 0; a < 3; a++) trans[a] = '0;
			princ = '0;
			inv_foc = '0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [47:0] val);
			case (idx)
				CFG_ROT_X:   rot[0] = val;
				CFG_ROT_Y:   rot[1] = val;
				CFG_ROT_Z:   rot[2] = val;
				CFG_TRANS_X: trans[0] = val[23:0];
				CFG_TRANS_Y: trans[1] = val[23:0];
				CFG_TRANS_Z: trans[2] = val[23:0];
				CFG_PRINC:   princ = val[31:0];
				CFG_INV_FOC: inv_foc = val;
				default: ;
			endcase
		endfunction

		// add half, then floor
		function longint round_down(longint v, int k);
			return (v + (longint'(1) <<< (k - 1))) >>> k;
		endfunction

		function longint coef(logic [47:0] row, int i);
			logic signed [15:0] w;
			w = row[16*i +: 16];
			return w;
		endfunction

		function world_point_t project(logic [10:0] r, logic [10:0] c, logic [15:0] d);
			world_point_t p;
			longint       cam [3];
			longint       acc;
			longint       v;
			logic [23:0]  res [3];
			bit           clipped;
			p = '0;
			if (d == DEPTH_NONE_LO || d == DEPTH_NONE_HI) begin
				no_measurement++;
				return p;
			end
			clipped = 0;
			// camera frame in Q.8
			cam[0] = round_down((longint'(c) * 16 - longint'(princ[15:0])) * longint'(d)
				* longint'(inv_foc[23:0]), CAM_SHIFT);
			cam[1] = round_down((longint'(r) * 16 - longint'(princ[31:16])) * longint'(d)
				* longint'(inv_foc[47:24]), CAM_SHIFT);
			cam[2] = longint'(d) <<< ZC_SHIFT;
			// rotate, round to mm, translate, clip
			for (int a = 0; a < 3; a++) begin
				acc = coef(rot[a], 0) * cam[0] + coef(rot[a], 1) * cam[1]
					+ coef(rot[a], 2) * cam[2];
				v = round_down(acc, ACC_SHIFT) + trans[a];
				if (v > SAT_MAX) begin
					v = SAT_MAX;
					clipped = 1;
				end
				if (v < SAT_MIN) begin
					v = SAT_MIN;
					clipped = 1;
				end
				res[a] = v[23:0];
			end
			if (clipped) saturated++;
			p.x = res[0];
			p.y = res[1];
			p.z = res[2];
			p.valid = 1'b1;
			return p;
		endfunction

		function void note_pixel(logic [10:0] r, logic [10:0] c, logic [15:0] d);
			expected_points.push_back(project(r, c, d));
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		task report(string what);
			errors++;
			if (errors <= 30) $display("tb: mismatch at %0t: %s", $time, what);
		endtask

		task check_point(logic [3*WORLD_BITS-1:0] data, logic valid);
			world_point_t e;
			if (expected_points.size() == 0) begin
				report("output item with no pixel outstanding");
				return;
			end
			e = expected_points.pop_front();
			checked++;
			if (data[23:0] !== e.x)
				report($sformatf("world_x %h, expected %h", data[23:0], e.x));
			if (data[47:24] !== e.y)
				report($sformatf("world_y %h, expected %h", data[47:24], e.y));
			if (data[71:48] !== e.z)
				report($sformatf("world_z %h, expected %h", data[71:48], e.z));
			if (valid !== e.valid)
				report($sformatf("point_valid %b, expected %b", valid, e.valid));
		endtask
	endclass

	logic                             clk;
	logic                             arst_n      = 1'b0;
	logic                             s_tvalid    = 1'b0;
	logic                             s_tready;
	logic [DATA_W-1:0]                s_tdata     = '0;
	logic                             m_tvalid;
	logic                             m_tready    = 1'b0;
	logic [3*WORLD_BITS-1:0]          m_tdata;
	logic                             m_tuser;
	logic                             cfg_we      = 1'b0;
	logic [CFG_INDEX_BITS-1:0]        cfg_index   = '0;
	logic [CFG_DATA_BITS-1:0]         cfg_wdata   = '0;

	logic            hold_active = 1'b0;
	int              idle_pct    = 0;
	int              stall_pct   = 0;
	int              n_settings  = 0;
	point_scoreboard sb;

	depth_pixel_to_world_point #(
		.PIXEL_INDEX_BITS(PIB)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	// output side: check accepted items, then choose the next ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_point(m_tdata, m_tuser);
			m_tready <= hold_active ? 1'b0 : ($urandom_range(99) >= stall_pct);
		end
	end

	// long output hold while the input side keeps offering
	task automatic hold_output(int cycles);
		fork
			begin
				hold_active <= 1'b1;
				repeat (cycles) @(posedge clk);
				hold_active <= 1'b0;
			end
		join_none
	endtask

	// offer one pixel, idling cycle by cycle first, and wait for it to be taken
	task automatic send_pixel(logic [10:0] r, logic [10:0] c, logic [15:0] d);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= DATA_W'({d, c, r});
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(r, c, d);
	endtask

	// stop offering and let every outstanding point come out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [47:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// write all eight registers; junk above the narrow ones must be ignored
	task automatic apply_setting(cam_setting_t s);
		write_reg(CFG_ROT_X, s.rx);
		write_reg(CFG_ROT_Y, s.ry);
		write_reg(CFG_ROT_Z, s.rz);
		write_reg(CFG_TRANS_X, {24'($urandom), s.tx});
		write_reg(CFG_TRANS_Y, {24'($urandom), s.ty});
		write_reg(CFG_TRANS_Z, {24'($urandom), s.tz});
		write_reg(CFG_PRINC, {16'($urandom), s.princ});
		write_reg(CFG_INV_FOC, s.ifoc);
		cfg_we <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	function automatic logic [15:0] rand_coef();
		int v;
		v = int'($urandom_range(0, 32768)) - 16384;
		return v[15:0];
	endfunction

	function automatic logic [23:0] rand_trans();
		int v;
		v = int'($urandom_range(0, 200000)) - 100000;
		return v[23:0];
	endfunction

	// realistic camera and pose, outputs mostly in range
	function automatic cam_setting_t plausible_setting();
		cam_setting_t s;
		s.rx    = {rand_coef(), rand_coef(), rand_coef()};
		s.ry    = {rand_coef(), rand_coef(), rand_coef()};
		s.rz    = {rand_coef(), rand_coef(), rand_coef()};
		s.tx    = rand_trans();
		s.ty    = rand_trans();
		s.tz    = rand_trans();
		s.princ = {16'($urandom_range(0, 16384)), 16'($urandom_range(0, 16384))};
		s.ifoc  = {24'($urandom_range(8000, 60000)), 24'($urandom_range(8000, 60000))};
		return s;
	endfunction

	// every register bit at random
	function automatic cam_setting_t wild_setting();
		cam_setting_t s;
		s.rx    = {16'($urandom), 32'($urandom)};
		s.ry    = {16'($urandom), 32'($urandom)};
		s.rz    = {16'($urandom), 32'($urandom)};
		s.tx    = 24'($urandom);
		s.ty    = 24'($urandom);
		s.tz    = 24'($urandom);
		s.princ = 32'($urandom);
		s.ifoc  = {16'($urandom), 32'($urandom)};
		return s;
	endfunction

	function automatic logic [15:0] rand_depth();
		int sel;
		sel = $urandom_range(99);
		if (sel < 4) return DEPTH_NONE_LO;
		if (sel < 8) return DEPTH_NONE_HI;
		if (sel < 20) return 16'($urandom_range(1, 255));
		if (sel < 26) return $urandom_range(1) ? 16'd65534 : 16'd1;
		return 16'($urandom_range(1, 65534));
	endfunction

	initial begin
		cam_setting_t s;
		int           idle_mix [4];
		int           stall_mix [4];
		sb = new();
		idle_mix  = '{0, 45, 0, 14};
		stall_mix = '{0, 0, 45, 14};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register reset values: identity pose, zero intrinsics
		send_pixel(11'd0, 11'd0, 16'd0);
		send_pixel(11'd2047, 11'd2047, 16'd65535);
		send_pixel(11'd5, 11'd7, 16'd1);
		send_pixel(11'd2047, 11'd0, 16'd65534);
		send_pixel(11'd0, 11'd2047, 16'd1234);
		drain();

		// typical camera, pose pulls z back so the centre pixel lands on the origin
		s.rx = ROT_X_RESET;
		s.ry = ROT_Y_RESET;
		s.rz = ROT_Z_RESET;
		s.tx = '0;
		s.ty = '0;
		s.tz = -24'sd1000;
		s.princ = {16'(240*16), 16'(320*16)};
		s.ifoc = {24'd31956, 24'd31956};
		apply_setting(s);
		send_pixel(11'd240, 11'd320, 16'd1000);
		send_pixel(11'd0, 11'd0, 16'd1);
		send_pixel(11'd479, 11'd639, 16'd4000);
		send_pixel(11'd2047, 11'd2047, 16'd65534);
		send_pixel(11'd0, 11'd0, 16'd65535);
		drain();

		// extremes driving every axis to the positive clip
		s.rx = {3{16'h7FFF}};
		s.ry = {3{16'h7FFF}};
		s.rz = {3{16'h7FFF}};
		s.tx = 24'h7FFFFF;
		s.ty = 24'h7FFFFF;
		s.tz = 24'h7FFFFF;
		s.princ = '0;
		s.ifoc = '1;
		apply_setting(s);
		send_pixel(11'd2047, 11'd2047, 16'd65534);
		send_pixel(11'd0, 11'd0, 16'd1);
		send_pixel(11'd1024, 11'd1024, 16'd30000);
		drain();

		// extremes toward the negative clip, largest principal point
		s.rx = {3{16'h8000}};
		s.ry = {3{16'h8000}};
		s.rz = {3{16'h8000}};
		s.tx = 24'h800000;
		s.ty = 24'h800000;
		s.tz = 24'h800000;
		s.princ = '1;
		s.ifoc = '1;
		apply_setting(s);
		send_pixel(11'd2047, 11'd2047, 16'd65534);
		send_pixel(11'd0, 11'd0, 16'd1);
		send_pixel(11'd1024, 11'd1024, 16'd30000);
		send_pixel(11'd0, 11'd0, 16'd0);
		drain();

		// random pixels over idle mixes and settings
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = idle_mix[ph];
			stall_pct = stall_mix[ph];
			for (int k = 0; k < 4; k++) begin
				apply_setting(k == 3 ? wild_setting() : plausible_setting());
				for (int i = 0; i < 100; i++) begin
					if (ph == 0 && k == 0 && i == 30) hold_output(80);
					send_pixel(11'($urandom), 11'($urandom), rand_depth());
				end
				drain();
			end
		end

		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d points never arrived", sb.pending()));
		$display("tb: %0d points checked, %0d without measurement, %0d clipped",
			sb.checked, sb.no_measurement, sb.saturated);
		$display("tb: %0d register settings, idle and stall mixes, one long output hold",
			n_settings);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: files.f
src/dpw_pkg.sv
src/dpw_backproj.sv
src/dpw_axis.sv
src/dpw_pose.sv
src/depth_pixel_to_world_point.sv
src/dpw_checker.sv
tb/tb_depth_pixel_to_world_point.sv
